// ===== src/rasm_pkg.sv =====
// Shared types and constants for the read assignment sampler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package rasm_pkg;

  localparam int unsigned ID_W    = 10;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned WGT_W   = 32;
  localparam int unsigned TOTAL_W = 38;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned MUL_A_W = 38;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned SCALE_W = TOTAL_W + FRAC_W;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_THETA = 2'd1,
    OP_ALIGN = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_THRD,
    S_MUL1,
    S_MUL2,
    S_SCALE,
    S_SCALEW,
    S_SRD,
    S_SACC,
    S_CHOOSE,
    S_CNT
  } state_e;

  // Operand set driven into the shared multiplier
  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

// ===== src/rasm_mul.sv =====
// Shared registered multiplier used for weights and draw scaling.
// Depends on rasm_pkg.
`timescale 1ns / 1ps
module rasm_mul (
  input  logic                      clk_i,
  input  rasm_pkg::mul_req_t        req_i,
  output logic [rasm_pkg::MUL_P_W-1:0] p_o
);
  import rasm_pkg::*;

  logic [MUL_P_W-1:0] p_q;

  // Capture the product only when a new operand pair is issued
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      p_q <= MUL_P_W'(req_i.a) * MUL_P_W'(req_i.b);
    end
  end

  assign p_o = p_q;
endmodule

// ===== src/rasm_mem.sv =====
// Simple dual-port memory: one write port, one read port with registered data.
// Depends on rasm_pkg only for house consistency.
`timescale 1ns / 1ps
module rasm_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  import rasm_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/read_assignment_sampler.sv =====
// Read assignment sampler top level: sequencer, tables and alignment buffer.
// Depends on rasm_pkg, rasm_mul and rasm_mem.
// Flow: a clear sweeps the count table; a theta load is written on acceptance;
//   an alignment reads theta and is weighted by the shared multiplier; the last
//   alignment scales the draw, walks the buffer and bumps the chosen count.
// One transaction at a time: the input is held off while the sequencer is busy.
// Reset: control clears at once, then a pass over every entry zeroes counts.
`timescale 1ns / 1ps
module read_assignment_sampler #(
  parameter int unsigned TRANSCRIPTS    = 1024,
  parameter int unsigned MAX_ALIGNMENTS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rasm_pkg::FRAC_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     operation_i,
  input  logic [rasm_pkg::ID_W-1:0]      transcript_i,
  input  logic [rasm_pkg::FRAC_W-1:0]    value_i,
  input  logic                           last_alignment_i,
  input  logic [rasm_pkg::FRAC_W-1:0]    uniform_draw_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           result_kind_o,
  output logic [rasm_pkg::ID_W-1:0]      chosen_transcript_o,
  output logic [rasm_pkg::CNT_W-1:0]     count_o,
  output logic                           overflow_o
);
  import rasm_pkg::*;

  localparam int unsigned TAW = (TRANSCRIPTS > 1) ? $clog2(TRANSCRIPTS) : 1;
  localparam int unsigned BAW = (MAX_ALIGNMENTS > 1) ? $clog2(MAX_ALIGNMENTS) : 1;
  localparam int unsigned BCW = $clog2(MAX_ALIGNMENTS + 1);
  localparam logic [16:0] TLIM    = 17'(TRANSCRIPTS);
  localparam logic [BCW-1:0] BMAX = BCW'(MAX_ALIGNMENTS);
  localparam logic [TAW-1:0] TLAST = TAW'(TRANSCRIPTS - 1);

  state_e state_q, state_d;

  logic [FRAC_W-1:0]  af_q;
  logic [ID_W-1:0]    id_q, id_d;
  logic [FRAC_W-1:0]  val_q, val_d;
  logic               last_q, last_d;
  logic [FRAC_W-1:0]  draw_q, draw_d;
  logic [FRAC_W-1:0]  theta_q, theta_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [BCW-1:0]     bcnt_q, bcnt_d;
  logic               ovf_q, ovf_d;
  logic [TOTAL_W-1:0] sum_q, sum_d;
  logic [BCW-1:0]     j_q, j_d;
  logic [ID_W-1:0]    lastid_q, lastid_d;
  logic               kind_q, kind_d;
  logic [TAW-1:0]     clr_q, clr_d;

  logic               out_valid_q, out_valid_d;
  logic               out_kind_q, out_kind_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;
  logic               out_ovf_q, out_ovf_d;

  mul_req_t           mul_req;
  logic [MUL_P_W-1:0] mul_p;

  logic               th_we, th_re;
  logic [TAW-1:0]     th_waddr, th_raddr;
  logic [FRAC_W-1:0]  th_rdata;
  logic               ct_we, ct_re;
  logic [TAW-1:0]     ct_waddr, ct_raddr;
  logic [CNT_W-1:0]   ct_wdata, ct_rdata;
  logic               bf_we, bf_re;
  logic [BAW-1:0]     bf_waddr, bf_raddr;
  logic [WGT_W-1:0]   wb_rdata, weight;
  logic [ID_W-1:0]    ib_rdata;

  logic               accept, out_free, id_in_range, searching;
  logic [SCALE_W-1:0] scaled_sum;

  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign id_in_range = {7'd0, id_q} < TLIM;
  assign scaled_sum  = {sum_q, 16'd0};
  assign searching   = (scaled_sum < mul_p[SCALE_W-1:0]) && (j_q < bcnt_q);

  rasm_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .p_o   (mul_p)
  );

  rasm_mem #(.DEPTH(TRANSCRIPTS), .WIDTH(FRAC_W)) u_theta (
    .clk_i, .we_i(th_we), .waddr_i(th_waddr), .wdata_i(value_i),
    .re_i(th_re), .raddr_i(th_raddr), .rdata_o(th_rdata)
  );

  rasm_mem #(.DEPTH(TRANSCRIPTS), .WIDTH(CNT_W)) u_count (
    .clk_i, .we_i(ct_we), .waddr_i(ct_waddr), .wdata_i(ct_wdata),
    .re_i(ct_re), .raddr_i(ct_raddr), .rdata_o(ct_rdata)
  );

  rasm_mem #(.DEPTH(MAX_ALIGNMENTS), .WIDTH(WGT_W)) u_wbuf (
    .clk_i, .we_i(bf_we), .waddr_i(bf_waddr), .wdata_i(weight),
    .re_i(bf_re), .raddr_i(bf_raddr), .rdata_o(wb_rdata)
  );

  rasm_mem #(.DEPTH(MAX_ALIGNMENTS), .WIDTH(ID_W)) u_ibuf (
    .clk_i, .we_i(bf_we), .waddr_i(bf_waddr), .wdata_i(id_q),
    .re_i(bf_re), .raddr_i(bf_raddr), .rdata_o(ib_rdata)
  );

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      af_q <= '0;
    end else if (cfg_we_i) begin
      af_q <= cfg_wdata_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      bcnt_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      bcnt_q      <= bcnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    val_q      <= val_d;
    last_q     <= last_d;
    draw_q     <= draw_d;
    theta_q    <= theta_d;
    sum_q      <= sum_d;
    j_q        <= j_d;
    lastid_q   <= lastid_d;
    kind_q     <= kind_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_cnt_q  <= out_cnt_d;
    out_ovf_q  <= out_ovf_d;
  end

  // Sequencer: next state, memory ports and multiplier operands
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    total_d     = total_q;
    bcnt_d      = bcnt_q;
    ovf_d       = ovf_q;
    id_d        = id_q;
    val_d       = val_q;
    last_d      = last_q;
    draw_d      = draw_q;
    theta_d     = theta_q;
    sum_d       = sum_q;
    j_d         = j_q;
    lastid_d    = lastid_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_cnt_d   = out_cnt_q;
    out_ovf_d   = out_ovf_q;
    in_ready_o  = 1'b0;
    mul_req     = '{en: 1'b0, a: '0, b: '0};
    th_we       = 1'b0;
    th_re       = 1'b0;
    th_waddr    = TAW'(transcript_i);
    th_raddr    = TAW'(transcript_i);
    ct_we       = 1'b0;
    ct_re       = 1'b0;
    ct_waddr    = clr_q;
    ct_wdata    = '0;
    ct_raddr    = TAW'(transcript_i);
    bf_we       = 1'b0;
    bf_re       = 1'b0;
    bf_waddr    = bcnt_q[BAW-1:0];
    bf_raddr    = j_q[BAW-1:0];
    weight      = mul_p[WGT_W-1:0];

    case (state_q)
      // Sweep the count table to zero
      S_CLEAR: begin
        ct_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == TLAST) begin
          clr_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        id_d   = transcript_i;
        val_d  = value_i;
        last_d = last_alignment_i;
        draw_d = uniform_draw_i;
        if (accept) begin
          case (operation_i)
            OP_CLEAR: state_d = S_CLEAR;
            OP_THETA: th_we = {7'd0, transcript_i} < TLIM;
            OP_READ: begin
              ct_re   = 1'b1;
              kind_d  = 1'b1;
              state_d = S_CNT;
            end
            OP_ALIGN: begin
              kind_d = 1'b0;
              if (bcnt_q < BMAX) begin
                th_re   = 1'b1;
                state_d = S_THRD;
              end else begin
                ovf_d = 1'b1;
                if (last_alignment_i) state_d = S_SCALE;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // Theta ready; issue probability times fraction (one minus it for id 0)
      S_THRD: begin
        theta_d     = id_in_range ? th_rdata : '0;
        mul_req.en  = 1'b1;
        mul_req.a   = MUL_A_W'(val_q);
        mul_req.b   = (id_q == '0) ? (17'd65536 - {1'b0, af_q}) : {1'b0, af_q};
        state_d     = S_MUL1;
      end

      // Noise weight is final here; others need the theta product
      S_MUL1: begin
        if (id_q == '0) begin
          bf_we   = 1'b1;
          total_d = total_q + TOTAL_W'(weight);
          bcnt_d  = bcnt_q + 1'b1;
          state_d = last_q ? S_SCALE : S_IDLE;
        end else begin
          mul_req.en = 1'b1;
          mul_req.a  = MUL_A_W'(mul_p[WGT_W-1:0]);
          mul_req.b  = MUL_B_W'(theta_q);
          state_d    = S_MUL2;
        end
      end

      S_MUL2: begin
        weight  = mul_p[WGT_W+15:16];
        bf_we   = 1'b1;
        total_d = total_q + TOTAL_W'(mul_p[WGT_W+15:16]);
        bcnt_d  = bcnt_q + 1'b1;
        state_d = last_q ? S_SCALE : S_IDLE;
      end

      // Scale the draw by the weight total
      S_SCALE: begin
        mul_req.en = 1'b1;
        mul_req.a  = total_q;
        mul_req.b  = MUL_B_W'(draw_q);
        state_d    = S_SCALEW;
      end

      S_SCALEW: begin
        sum_d   = '0;
        j_d     = '0;
        state_d = S_SRD;
      end

      // Walk the buffer until the running sum reaches the scaled draw or the buffer ends
      S_SRD: begin
        if (searching) begin
          bf_re   = 1'b1;
          state_d = S_SACC;
        end else begin
          state_d = S_CHOOSE;
        end
      end

      S_SACC: begin
        sum_d    = sum_q + TOTAL_W'(wb_rdata);
        lastid_d = ib_rdata;
        j_d      = j_q + 1'b1;
        state_d  = S_SRD;
      end

      S_CHOOSE: begin
        id_d     = (j_q == '0) ? '0 : lastid_q;
        ct_re    = 1'b1;
        ct_raddr = TAW'((j_q == '0) ? '0 : lastid_q);
        state_d  = S_CNT;
      end

      // Bump the count (assignment only) and publish the transaction
      S_CNT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_id_d    = id_q;
          out_ovf_d   = kind_q ? 1'b0 : ovf_q;
          out_cnt_d   = '0;
          if (id_in_range) begin
            out_cnt_d = ct_rdata;
            if (!kind_q && ct_rdata != '1) begin
              out_cnt_d = ct_rdata + 1'b1;
            end
          end
          if (!kind_q) begin
            ct_we    = id_in_range;
            ct_waddr = TAW'(id_q);
            ct_wdata = out_cnt_d;
            total_d  = '0;
            bcnt_d   = '0;
            ovf_d    = 1'b0;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = out_kind_q;
  assign chosen_transcript_o = out_id_q;
  assign count_o             = out_cnt_q;
  assign overflow_o          = out_ovf_q;
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for read_assignment_sampler: random and directed items,
// predicted transcript assignments and count read-outs. Depends on rasm_pkg.
`timescale 1ns / 1ps
module tb;
  import rasm_pkg::*;

  localparam int unsigned NTR = 1024;
  localparam int unsigned NBUF = 64;

  typedef struct packed {
    op_e         op;
    logic [9:0]  tid;
    logic [15:0] val;
    logic        last;
    logic [15:0] draw;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  tid;
    logic [31:0] cnt;
    logic        ovf;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] operation_i = '0;
  logic [9:0] transcript_i = '0;
  logic [15:0] value_i = '0;
  logic last_alignment_i = 1'b0;
  logic [15:0] uniform_draw_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic result_kind_o;
  logic [9:0] chosen_transcript_o;
  logic [31:0] count_o;
  logic overflow_o;

  read_assignment_sampler dut (.*);

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  req_t pending_q[$];
  res_t expected_q[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   in_acc = 1'b0;

  // Predictor state
  logic [15:0] frac_m;
  logic [15:0] theta_m[NTR];
  bit          theta_set[NTR];
  logic [31:0] count_m[NTR];
  logic [31:0] wbuf_m[NBUF];
  logic [9:0]  ibuf_m[NBUF];
  logic [37:0] total_m;
  int          nbuf_m;
  bit          ovf_m;

  // Advance the predictor by one accepted transaction
  task automatic predict_sample(input req_t r);
    logic [63:0] w, scaled, run;
    int j;
    logic [9:0] pick;
    res_t e;
    case (r.op)
      OP_CLEAR: for (int i = 0; i < NTR; i++) count_m[i] = '0;
      OP_THETA: theta_m[r.tid] = r.val;
      OP_READ: begin
        e = '{kind: 1'b1, tid: r.tid, cnt: count_m[r.tid], ovf: 1'b0};
        expected_q.push_back(e);
      end
      default: begin
        if (nbuf_m < NBUF) begin
          if (r.tid == 0) w = 64'(r.val) * (64'd65536 - 64'(frac_m));
          else w = (64'(r.val) * 64'(frac_m) * 64'(theta_m[r.tid])) >> 16;
          wbuf_m[nbuf_m] = w[31:0];
          ibuf_m[nbuf_m] = r.tid;
          total_m = total_m + 38'(w[31:0]);
          nbuf_m++;
        end else ovf_m = 1'b1;
        if (r.last) begin
          scaled = 64'(r.draw) * 64'(total_m);
          run = '0;
          j = 0;
          while ((run << 16) < scaled && j < nbuf_m) begin
            run += 64'(wbuf_m[j]);
            j++;
          end
          pick = (j == 0) ? 10'd0 : ibuf_m[j-1];
          if (count_m[pick] != 32'hFFFF_FFFF) count_m[pick]++;
          e = '{kind: 1'b0, tid: pick, cnt: count_m[pick], ovf: ovf_m};
          expected_q.push_back(e);
          total_m = '0;
          nbuf_m = 0;
          ovf_m = 1'b0;
        end
      end
    endcase
  endtask

  // Note input acceptance at the rising edge
  always @(posedge clk_i) begin
    in_acc <= rst_ni && in_valid_i && in_ready_o;
  end

  // Driver: hold the transaction until accepted, change inputs at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc) predict_sample(pending_q.pop_front());
      if ((in_acc || !in_valid_i) && pending_q.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        operation_i <= pending_q[0].op;
        transcript_i <= pending_q[0].tid;
        value_i <= pending_q[0].val;
        last_alignment_i <= pending_q[0].last;
        uniform_draw_i <= pending_q[0].draw;
      end else if (in_acc) begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each delivered result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d id=%0d count=%0d", $time,
                 result_kind_o, chosen_transcript_o, count_o);
        errors++;
      end else begin
        res_t e;
        e = expected_q.pop_front();
        if (e.kind !== result_kind_o)
          $display("%0t: kind exp %0d got %0d", $time, e.kind, result_kind_o);
        if (e.tid !== chosen_transcript_o)
          $display("%0t: transcript exp %0d got %0d", $time, e.tid, chosen_transcript_o);
        if (e.cnt !== count_o)
          $display("%0t: count exp %0d got %0d", $time, e.cnt, count_o);
        if (e.ovf !== overflow_o)
          $display("%0t: overflow exp %0d got %0d", $time, e.ovf, overflow_o);
        if (e !== {result_kind_o, chosen_transcript_o, count_o, overflow_o}) errors++;
      end
    end
  end

  function automatic req_t mk(op_e op, int tid, int val, bit last, int draw);
    mk = '{op: op, tid: 10'(tid), val: 16'(val), last: last, draw: 16'(draw)};
  endfunction

  // Mark ids with a theta loaded; random alignments only target those ids
  task automatic push_item(input req_t r);
    if (r.op == OP_THETA) theta_set[r.tid] = 1'b1;
    pending_q.push_back(r);
  endtask

  function automatic int loaded_id();
    int t;
    do t = $urandom_range(NTR - 1); while (t != 0 && !theta_set[t]);
    return t;
  endfunction

  // Wait until the block has drained, including the clear pass
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (NTR + 50) @(posedge clk_i);
  endtask

  task automatic write_frac(input logic [15:0] f);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= f;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    frac_m = f;
  endtask

  // Queue one read of n alignments, all to ids marked as loaded
  task automatic push_read(input int n);
    for (int k = 0; k < n; k++)
      push_item(mk(OP_ALIGN, loaded_id(), $urandom_range(65535), k == n - 1,
                   $urandom_range(65535)));
  endtask

  initial begin
    frac_m = '0;
    total_m = '0;
    nbuf_m = 0;
    ovf_m = 1'b0;
    for (int i = 0; i < NTR; i++) begin
      count_m[i] = '0;
      theta_m[i] = '0;
      theta_set[i] = 1'b0;
    end
    theta_set[0] = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // Directed: extremes, every operation, zero draw, zero total, overflow
    write_frac(16'hFFFF);
    push_item(mk(OP_THETA, 1023, 65535, 0, 0));
    push_item(mk(OP_THETA, 1, 0, 0, 0));
    push_item(mk(OP_THETA, 5, 1, 0, 0));
    push_item(mk(OP_ALIGN, 1023, 65535, 0, 0));
    push_item(mk(OP_ALIGN, 0, 65535, 1, 65535));
    push_item(mk(OP_ALIGN, 5, 100, 1, 0));
    push_item(mk(OP_ALIGN, 1, 65535, 1, 65535));
    push_item(mk(OP_READ, 1023, 0, 0, 0));
    push_item(mk(OP_READ, 0, 0, 0, 0));
    push_item(mk(OP_CLEAR, 0, 0, 0, 0));
    push_item(mk(OP_READ, 1023, 0, 0, 0));
    push_item(mk(OP_THETA, 1022, 32768, 0, 0));
    push_item(mk(OP_ALIGN, 1022, 1, 0, 0));
    push_item(mk(OP_ALIGN, 1022, 65535, 1, 32768));
    drain();
    write_frac(16'h0000);
    push_read(NBUF + 5);
    push_item(mk(OP_ALIGN, 0, 0, 1, 65535));
    push_item(mk(OP_READ, 1022, 0, 0, 0));
    drain();

    // Random phases with different idling and settings
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 46 : 19) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 46 : 19) : 0;
      write_frac(ph == 0 ? 16'h8000 : 16'($urandom_range(65535)));
      for (int n = 0; n < 45; n++) begin
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) push_item(mk(OP_THETA, $urandom_range(NTR - 1),
                                   $urandom_range(65535), $urandom_range(1),
                                   $urandom_range(65535)));
        else if (sel < 22) push_item(mk(OP_READ, loaded_id(), $urandom_range(65535),
                                        $urandom_range(1), $urandom_range(65535)));
        else if (sel < 24) push_item(mk(OP_CLEAR, $urandom_range(NTR - 1), 0, 0, 0));
        else if (sel < 26) push_read(NBUF + $urandom_range(3));
        else push_read($urandom_range(1, 4));
        if (n == 20) begin
          // Hold off until the block has delivered everything
          while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0)
            @(posedge clk_i);
        end
      end
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== sim.f =====
src/rasm_pkg.sv
src/rasm_mul.sv
src/rasm_mem.sv
src/read_assignment_sampler.sv
bench/tb.sv
